@@ src/tkrs_pkg.sv @@
`default_nettype none

package tkrs_pkg;

    // Heap storage and sample sizes
    localparam int CAPACITY   = 1024;
    localparam int VALUE_BITS = 32;

    // Fixed field widths
    localparam int STORE_W = 31;
    localparam int SUM_W   = 41;
    localparam int IDX_W   = 32;
    localparam int DECAY_W = 16;
    localparam int KEEP_W  = 11;
    localparam int PROD_W  = IDX_W + DECAY_W;

    // Derived heap index widths
    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int LIM_W  = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;
    localparam int J_W    = ADDR_W + 2;

    // Stream payload widths, padded to whole bytes
    localparam int SDATA_W = ((VALUE_BITS + 7) / 8) * 8;
    localparam int MDATA_W = ((SUM_W + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;
    localparam logic REG_KEEP  = 1'b0;
    localparam logic REG_DECAY = 1'b1;
    localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(1);

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_DECIDE = 10'b00_0000_0010,
        ST_ROOT   = 10'b00_0000_0100,
        ST_SUM    = 10'b00_0000_1000,
        ST_BEST   = 10'b00_0001_0000,
        ST_UP     = 10'b00_0010_0000,
        ST_UP_CMP = 10'b00_0100_0000,
        ST_DN     = 10'b00_1000_0000,
        ST_DN_CMP = 10'b01_0000_0000,
        ST_OUT    = 10'b10_0000_0000
    } state_t;

    typedef struct packed {
        logic clear;
        logic step;
        logic add_en;
        logic best_en;
    } score_ctrl_t;

endpackage

`default_nettype wire

@@ src/tkrs_ram.sv @@
`default_nettype none

// One write port, two registered read ports.
module tkrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] ra_addr,
    output logic      [WIDTH-1:0]                        ra_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rb_addr,
    output logic      [WIDTH-1:0]                        rb_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        ra_data <= mem[ra_addr];
        rb_data <= mem[rb_addr];
    end

endmodule

`default_nettype wire

@@ src/tkrs_score.sv @@
`default_nettype none

// Item index, running sum and best score with the decay product.
module tkrs_score (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire tkrs_pkg::score_ctrl_t        ctrl,
    input  wire logic [tkrs_pkg::STORE_W-1:0] addend,
    input  wire logic [tkrs_pkg::DECAY_W-1:0] decay,
    output logic      [tkrs_pkg::SUM_W-1:0]   best
);

    localparam int SC_W = ((tkrs_pkg::PROD_W > tkrs_pkg::SUM_W) ?
                           tkrs_pkg::PROD_W : tkrs_pkg::SUM_W) + 1;

    logic [tkrs_pkg::IDX_W-1:0]  index_reg, index_next, index_base;
    logic [tkrs_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic [tkrs_pkg::SUM_W-1:0]  best_reg, best_next;
    logic [tkrs_pkg::PROD_W-1:0] prod_reg;
    logic [tkrs_pkg::SUM_W:0]    sum_wide;
    logic signed [SC_W-1:0]      score;
    logic signed [SC_W-1:0]      best_ext;

    assign sum_wide   = {1'b0, sum_reg} + (tkrs_pkg::SUM_W + 1)'(addend);
    assign score      = $signed(SC_W'(sum_reg)) - $signed(SC_W'(prod_reg));
    assign best_ext   = $signed(SC_W'(best_reg));
    assign index_base = ctrl.clear ? '0 : index_reg;

    always_comb begin
        index_next = index_reg;
        sum_next   = sum_reg;
        best_next  = best_reg;
        if (ctrl.step) begin
            // saturate the index at its maximum
            index_next = (&index_base) ? index_base : index_base + 1'b1;
            if (ctrl.clear) begin
                sum_next  = '0;
                best_next = '0;
            end
        end
        if (ctrl.add_en) begin
            sum_next = sum_wide[tkrs_pkg::SUM_W] ? '1 : sum_wide[tkrs_pkg::SUM_W-1:0];
        end
        if (ctrl.best_en && (score > best_ext)) begin
            best_next = score[tkrs_pkg::SUM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            index_reg <= '0;
            sum_reg   <= '0;
            best_reg  <= '0;
        end else begin
            index_reg <= index_next;
            sum_reg   <= sum_next;
            best_reg  <= best_next;
        end
    end

    // Free-running product; the index settles before any use.
    always_ff @(posedge aclk) begin
        prod_reg <= index_reg * decay;
    end

    assign best = best_reg;

endmodule

`default_nettype wire

@@ src/top_k_running_sum_with_decay_unit.sv @@
`default_nettype none
// Sequencing: a skipped sample goes from accept through the decide and output states; a
//   kept sample also updates the sum and best score, then sifts the heap up or down.
// Flow: one request at a time, accepted only while idle; each heap
//   level costs a read state, then a compare and write state; a stalled result holds it.
// Reset: synchronous, active-low aresetn clears the sequencer, fill count, sum,
//   index, best score and output valid; heap RAM contents are not cleared.

module top_k_running_sum_with_decay_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [tkrs_pkg::SDATA_W-1:0]  s_tdata,   // [VALUE_BITS-1:0] value_in
    input  wire logic [0:0]                    s_tuser,   // [0] first
    input  wire logic                          s_tlast,   // last
    // Result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [tkrs_pkg::MDATA_W-1:0]  m_tdata,   // [40:0] best_score, rest zero
    output logic                               m_tlast,   // final_flag
    // Configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tkrs_pkg::CFG_AW-1:0]   paddr,
    input  wire logic [tkrs_pkg::CFG_DW-1:0]   pwdata,
    output logic      [tkrs_pkg::CFG_DW-1:0]   prdata,
    output logic                               pready
);

    localparam int AW = tkrs_pkg::ADDR_W;
    localparam int SW = tkrs_pkg::STORE_W;
    localparam logic signed [63:0] STORE_CAP = {{(64 - SW){1'b0}}, {SW{1'b1}}};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [tkrs_pkg::KEEP_W-1:0]  keep_reg;
    logic [tkrs_pkg::DECAY_W-1:0] decay_reg;
    logic                         cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keep_reg  <= tkrs_pkg::KEEP_RESET;
            decay_reg <= '0;
        end else if (cfg_wr) begin
            case (paddr[tkrs_pkg::CFG_AW-1])
                tkrs_pkg::REG_KEEP:  keep_reg  <= pwdata[tkrs_pkg::KEEP_W-1:0];
                tkrs_pkg::REG_DECAY: decay_reg <= pwdata[tkrs_pkg::DECAY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[tkrs_pkg::CFG_AW-1])
            tkrs_pkg::REG_KEEP:  prdata = tkrs_pkg::CFG_DW'(keep_reg);
            tkrs_pkg::REG_DECAY: prdata = tkrs_pkg::CFG_DW'(decay_reg);
            default:             prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sample decode: sign-extend, skip non-positive, cap to the store width
    // ------------------------------------------------------------------
    logic signed [tkrs_pkg::VALUE_BITS-1:0] s_value;
    logic signed [63:0]                     value_ext;
    logic                                   value_pos;
    logic [SW-1:0]                          value_cap;

    assign s_value   = s_tdata[tkrs_pkg::VALUE_BITS-1:0];
    assign value_ext = 64'(s_value);
    assign value_pos = value_ext > 64'sd0;
    assign value_cap = (value_ext > STORE_CAP) ? {SW{1'b1}} : value_ext[SW-1:0];

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    tkrs_pkg::state_t              state_reg, state_next;
    logic [SW-1:0]                 v_reg, v_next;
    logic                          vpos_reg, vpos_next;
    logic                          last_reg, last_next;
    logic [tkrs_pkg::CNT_W-1:0]    fill_reg, fill_next;
    logic [SW-1:0]                 addend_reg, addend_next;
    logic                          ins_reg, ins_next;
    logic [AW-1:0]                 pos_reg, pos_next;
    logic [tkrs_pkg::J_W-1:0]      j_reg, j_next;
    logic                          m_valid_reg, m_valid_next;
    logic [tkrs_pkg::MDATA_W-1:0]  m_data_reg, m_data_next;
    logic                          m_last_reg, m_last_next;

    // Heap RAM port signals
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [SW-1:0] ram_wdata;
    logic [AW-1:0] ram_ra_addr, ram_rb_addr;
    logic [SW-1:0] ram_ra_data, ram_rb_data;

    tkrs_pkg::score_ctrl_t        score_ctrl;
    logic [tkrs_pkg::SUM_W-1:0]   best;

    logic                         s_accept;
    logic [tkrs_pkg::LIM_W-1:0]   limit;
    logic [tkrs_pkg::LIM_W-1:0]   fill_lim;
    logic [AW-1:0]                parent;
    logic [tkrs_pkg::J_W-1:0]     j_left;
    logic [tkrs_pkg::J_W-1:0]     j_right;
    logic [tkrs_pkg::J_W-1:0]     fill_j;
    logic                         right_ok;
    logic [SW-1:0]                child_val;
    logic [tkrs_pkg::J_W-1:0]     child_j;

    assign s_tready = (state_reg == tkrs_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // Effective heap size: keep count clipped to the capacity
    assign limit = (tkrs_pkg::LIM_W'(keep_reg) > tkrs_pkg::LIM_W'(tkrs_pkg::CAPACITY)) ?
                   tkrs_pkg::LIM_W'(tkrs_pkg::CAPACITY) : tkrs_pkg::LIM_W'(keep_reg);
    assign fill_lim = tkrs_pkg::LIM_W'(fill_reg);

    // Heap index arithmetic for the hole being moved
    assign parent   = AW'((pos_reg - 1'b1) >> 1);
    assign j_left   = {1'b0, pos_reg, 1'b1};
    assign fill_j   = tkrs_pkg::J_W'(fill_reg);
    assign j_right  = j_reg + 1'b1;
    assign right_ok = (j_right < fill_j) && (ram_rb_data < ram_ra_data);
    assign child_val = right_ok ? ram_rb_data : ram_ra_data;
    assign child_j   = right_ok ? j_right : j_reg;

    always_comb begin
        state_next   = state_reg;
        v_next       = v_reg;
        vpos_next    = vpos_reg;
        last_next    = last_reg;
        fill_next    = fill_reg;
        addend_next  = addend_reg;
        ins_next     = ins_reg;
        pos_next     = pos_reg;
        j_next       = j_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        ram_we       = 1'b0;
        ram_waddr    = pos_reg;
        ram_wdata    = v_reg;
        ram_ra_addr  = '0;
        ram_rb_addr  = '0;
        score_ctrl   = '0;

        // Drop the output register once the downstream takes it
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            tkrs_pkg::ST_IDLE: begin
                if (s_accept) begin
                    // Latch the request; a first flag clears heap fill, sum,
                    // index and best before this sample counts.
                    v_next           = value_cap;
                    vpos_next        = value_pos;
                    last_next        = s_tlast;
                    score_ctrl.step  = 1'b1;
                    score_ctrl.clear = s_tuser[0];
                    if (s_tuser[0]) begin
                        fill_next = '0;
                    end
                    state_next = tkrs_pkg::ST_DECIDE;
                end
            end
            tkrs_pkg::ST_DECIDE: begin
                if (!vpos_reg || (limit == '0)) begin
                    state_next = tkrs_pkg::ST_OUT;
                end else if (fill_lim < limit) begin
                    // Heap not full: insert at the end, sift up afterwards
                    addend_next = v_reg;
                    pos_next    = fill_reg[AW-1:0];
                    fill_next   = fill_reg + 1'b1;
                    ins_next    = 1'b1;
                    state_next  = tkrs_pkg::ST_SUM;
                end else if (fill_reg != '0) begin
                    // Heap full: fetch the minimum for the replace test
                    ram_ra_addr = '0;
                    ins_next    = 1'b0;
                    state_next  = tkrs_pkg::ST_ROOT;
                end else begin
                    state_next = tkrs_pkg::ST_OUT;
                end
            end
            tkrs_pkg::ST_ROOT: begin
                if (v_reg > ram_ra_data) begin
                    addend_next = v_reg - ram_ra_data;
                    state_next  = tkrs_pkg::ST_SUM;
                end else begin
                    state_next = tkrs_pkg::ST_OUT;
                end
            end
            tkrs_pkg::ST_SUM: begin
                score_ctrl.add_en = 1'b1;
                state_next        = tkrs_pkg::ST_BEST;
            end
            tkrs_pkg::ST_BEST: begin
                score_ctrl.best_en = 1'b1;
                if (ins_reg) begin
                    state_next = tkrs_pkg::ST_UP;
                end else begin
                    pos_next   = '0;
                    state_next = tkrs_pkg::ST_DN;
                end
            end
            tkrs_pkg::ST_UP: begin
                if (pos_reg == '0) begin
                    ram_we     = 1'b1;
                    state_next = tkrs_pkg::ST_OUT;
                end else begin
                    ram_ra_addr = parent;
                    state_next  = tkrs_pkg::ST_UP_CMP;
                end
            end
            tkrs_pkg::ST_UP_CMP: begin
                ram_ra_addr = parent;
                ram_we      = 1'b1;
                if (ram_ra_data <= v_reg) begin
                    state_next = tkrs_pkg::ST_OUT;
                end else begin
                    // Move the parent down into the hole and climb
                    ram_wdata  = ram_ra_data;
                    pos_next   = parent;
                    state_next = tkrs_pkg::ST_UP;
                end
            end
            tkrs_pkg::ST_DN: begin
                if (j_left >= fill_j) begin
                    ram_we     = 1'b1;
                    state_next = tkrs_pkg::ST_OUT;
                end else begin
                    ram_ra_addr = j_left[AW-1:0];
                    ram_rb_addr = AW'(j_left + 1'b1);
                    j_next      = j_left;
                    state_next  = tkrs_pkg::ST_DN_CMP;
                end
            end
            tkrs_pkg::ST_DN_CMP: begin
                ram_we = 1'b1;
                if (v_reg <= child_val) begin
                    state_next = tkrs_pkg::ST_OUT;
                end else begin
                    // Pull the smaller child up into the hole and descend
                    ram_wdata  = child_val;
                    pos_next   = child_j[AW-1:0];
                    state_next = tkrs_pkg::ST_DN;
                end
            end
            tkrs_pkg::ST_OUT: begin
                // Hold until the output register is free or being taken
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = tkrs_pkg::MDATA_W'(best);
                    m_last_next  = last_reg;
                    state_next   = tkrs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tkrs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tkrs_pkg::ST_IDLE;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg      <= v_next;
        vpos_reg   <= vpos_next;
        last_reg   <= last_next;
        addend_reg <= addend_next;
        ins_reg    <= ins_next;
        pos_reg    <= pos_next;
        j_reg      <= j_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // ------------------------------------------------------------------
    // Heap store and score datapath
    // ------------------------------------------------------------------
    tkrs_ram #(
        .WIDTH (SW),
        .DEPTH (tkrs_pkg::CAPACITY)
    ) u_heap (
        .clk     (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .ra_addr (ram_ra_addr),
        .ra_data (ram_ra_data),
        .rb_addr (ram_rb_addr),
        .rb_data (ram_rb_data)
    );

    tkrs_score u_score (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (score_ctrl),
        .addend  (addend_reg),
        .decay   (decay_reg),
        .best    (best)
    );

endmodule

`default_nettype wire

@@ src/tkrs_checker.sv @@
`default_nettype none

module tkrs_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_tvalid,
    input wire logic                         s_tready,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [tkrs_pkg::MDATA_W-1:0] m_tdata,
    input wire logic                         m_tlast
);

    // Reset empties the output register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // One request at a time: not ready again straight after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready ##1 !s_tready)
        else $error("request accepted while busy");

    // A new result is only loaded while the block is working
    a_result_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without work");

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule

bind top_k_running_sum_with_decay_unit tkrs_checker u_tkrs_checker (.*);

`default_nettype wire
